@@ sv/kbhc_pkg.sv @@
// Shared types, command codes and lookup tables for the keyboard host command handler.
`default_nettype none

package kbhc_pkg;

    // Input item kinds
    localparam logic CMD_KIND_HOST  = 1'b0;
    localparam logic CMD_KIND_QUERY = 1'b1;

    // Host command bytes
    localparam logic [7:0] CMD_RESET     = 8'hFF;
    localparam logic [7:0] CMD_RESEND    = 8'hFE;
    localparam logic [7:0] CMD_KEY_MAKE  = 8'hFD;
    localparam logic [7:0] CMD_KEY_MB    = 8'hFC;
    localparam logic [7:0] CMD_KEY_MT    = 8'hFB;
    localparam logic [7:0] CMD_GLB_ALL   = 8'hFA;
    localparam logic [7:0] CMD_GLB_MAKE  = 8'hF9;
    localparam logic [7:0] CMD_GLB_MB    = 8'hF8;
    localparam logic [7:0] CMD_GLB_MT    = 8'hF7;
    localparam logic [7:0] CMD_DEFAULTS  = 8'hF6;
    localparam logic [7:0] CMD_DISABLE   = 8'hF5;
    localparam logic [7:0] CMD_ENABLE    = 8'hF4;
    localparam logic [7:0] CMD_TYPEMATIC = 8'hF3;
    localparam logic [7:0] CMD_READ_ID   = 8'hF2;
    localparam logic [7:0] CMD_SCANSET   = 8'hF0;
    localparam logic [7:0] CMD_ECHO      = 8'hEE;
    localparam logic [7:0] CMD_LEDS      = 8'hED;

    // Reply bytes
    localparam logic [7:0] RSP_ACK    = 8'hFA;
    localparam logic [7:0] RSP_RESEND = 8'hFE;
    localparam logic [7:0] RSP_BAT_OK = 8'hAA;
    localparam logic [7:0] RSP_ID0    = 8'hAB;
    localparam logic [7:0] RSP_ID1    = 8'h83;
    localparam logic [7:0] RSP_ECHO   = 8'hEE;

    // Set 3 global modes
    localparam logic [1:0] MODE_MAKE     = 2'd0;
    localparam logic [1:0] MODE_MB       = 2'd1;
    localparam logic [1:0] MODE_MT       = 2'd2;
    localparam logic [1:0] MODE_ALL      = 2'd3;

    // Per-key map entries (bit0 break off, bit1 typematic off)
    localparam logic [1:0] KEY_ENT_NONE  = 2'd0;
    localparam logic [1:0] KEY_ENT_MT    = 2'd1;
    localparam logic [1:0] KEY_ENT_MB    = 2'd2;
    localparam logic [1:0] KEY_ENT_MAKE  = 2'd3;

    // Scan code sets
    localparam logic [1:0] SET_ONE   = 2'd1;
    localparam logic [1:0] SET_TWO   = 2'd2;
    localparam logic [1:0] SET_THREE = 2'd3;

    // Power-up / default values
    localparam logic [1:0] RST_SET    = SET_TWO;
    localparam logic [1:0] RST_GLOBAL = MODE_ALL;
    localparam logic [4:0] RST_RATE   = 5'd11;
    localparam logic [1:0] RST_DELAY  = 2'd1;

    typedef enum logic [4:0] {
        CC_RESET,
        CC_RESEND,
        CC_KEY_MAKE,
        CC_KEY_MB,
        CC_KEY_MT,
        CC_GLB_ALL,
        CC_GLB_MAKE,
        CC_GLB_MB,
        CC_GLB_MT,
        CC_DEFAULTS,
        CC_DISABLE,
        CC_ENABLE,
        CC_TYPEMATIC,
        CC_READ_ID,
        CC_SCANSET,
        CC_ECHO,
        CC_LEDS,
        CC_UNKNOWN,
        CC_QUERY
    } t_cmd_class;

    typedef enum logic [2:0] {
        WS_IDLE,
        WS_LEDS,
        WS_SCANSET,
        WS_TYPEMATIC,
        WS_KEY_MAKE,
        WS_KEY_MB,
        WS_KEY_MT
    } t_wait_state;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_back_state;

    // One classified item as it travels from front to back
    typedef struct packed {
        logic       is_query;
        t_cmd_class cls;
        logic       key_ok;
        logic [7:0] data;
    } t_cmd_entry;

    function automatic logic [18:0] rate_period_us(input logic [4:0] idx);
        logic [18:0] v;
        case (idx)
            5'd0:  v = 19'd33333;
            5'd1:  v = 19'd37453;
            5'd2:  v = 19'd41667;
            5'd3:  v = 19'd45872;
            5'd4:  v = 19'd48309;
            5'd5:  v = 19'd54054;
            5'd6:  v = 19'd58480;
            5'd7:  v = 19'd62500;
            5'd8:  v = 19'd66667;
            5'd9:  v = 19'd75188;
            5'd10: v = 19'd83333;
            5'd11: v = 19'd91743;
            5'd12: v = 19'd100000;
            5'd13: v = 19'd108696;
            5'd14: v = 19'd116279;
            5'd15: v = 19'd125000;
            5'd16: v = 19'd133333;
            5'd17: v = 19'd149254;
            5'd18: v = 19'd166667;
            5'd19: v = 19'd181818;
            5'd20: v = 19'd200000;
            5'd21: v = 19'd217391;
            5'd22: v = 19'd232558;
            5'd23: v = 19'd250000;
            5'd24: v = 19'd270270;
            5'd25: v = 19'd303030;
            5'd26: v = 19'd333333;
            5'd27: v = 19'd370370;
            5'd28: v = 19'd400000;
            5'd29: v = 19'd434783;
            5'd30: v = 19'd476190;
            default: v = 19'd500000;
        endcase
        return v;
    endfunction

    function automatic logic [9:0] delay_lookup(input logic [1:0] idx);
        logic [9:0] v;
        case (idx)
            2'd0:    v = 10'd250;
            2'd1:    v = 10'd500;
            2'd2:    v = 10'd750;
            default: v = 10'd1000;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] usb_led_order(input logic [2:0] led);
        logic [2:0] v;
        case (led)
            3'd0:    v = 3'd0;
            3'd1:    v = 3'd4;
            3'd2:    v = 3'd1;
            3'd3:    v = 3'd5;
            3'd4:    v = 3'd2;
            3'd5:    v = 3'd6;
            3'd6:    v = 3'd3;
            default: v = 3'd7;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ sv/kbhc_front.sv @@
// Front end: accept items, decode the host byte into a command class, queue them.
`default_nettype none

module kbhc_front #(
    parameter int KEY_MAP_DEPTH = 224
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire                  i_command,
    input  wire  [7:0]           i_data_value,
    output logic                 o_deq_valid,
    input  wire                  i_deq_ready,
    output kbhc_pkg::t_cmd_entry o_deq_entry
);

    localparam logic [8:0] DEPTH_LIMIT = 9'(KEY_MAP_DEPTH);

    kbhc_pkg::t_cmd_class cls;
    kbhc_pkg::t_cmd_entry ent;
    kbhc_pkg::t_cmd_entry r_ent [2];
    logic                 r_wr_ptr, n_wr_ptr;
    logic                 r_rd_ptr, n_rd_ptr;
    logic [1:0]           r_count, n_count;
    logic                 push, pop;

    always_comb begin
        unique case (i_data_value)
            kbhc_pkg::CMD_RESET:     cls = kbhc_pkg::CC_RESET;
            kbhc_pkg::CMD_RESEND:    cls = kbhc_pkg::CC_RESEND;
            kbhc_pkg::CMD_KEY_MAKE:  cls = kbhc_pkg::CC_KEY_MAKE;
            kbhc_pkg::CMD_KEY_MB:    cls = kbhc_pkg::CC_KEY_MB;
            kbhc_pkg::CMD_KEY_MT:    cls = kbhc_pkg::CC_KEY_MT;
            kbhc_pkg::CMD_GLB_ALL:   cls = kbhc_pkg::CC_GLB_ALL;
            kbhc_pkg::CMD_GLB_MAKE:  cls = kbhc_pkg::CC_GLB_MAKE;
            kbhc_pkg::CMD_GLB_MB:    cls = kbhc_pkg::CC_GLB_MB;
            kbhc_pkg::CMD_GLB_MT:    cls = kbhc_pkg::CC_GLB_MT;
            kbhc_pkg::CMD_DEFAULTS:  cls = kbhc_pkg::CC_DEFAULTS;
            kbhc_pkg::CMD_DISABLE:   cls = kbhc_pkg::CC_DISABLE;
            kbhc_pkg::CMD_ENABLE:    cls = kbhc_pkg::CC_ENABLE;
            kbhc_pkg::CMD_TYPEMATIC: cls = kbhc_pkg::CC_TYPEMATIC;
            kbhc_pkg::CMD_READ_ID:   cls = kbhc_pkg::CC_READ_ID;
            kbhc_pkg::CMD_SCANSET:   cls = kbhc_pkg::CC_SCANSET;
            kbhc_pkg::CMD_ECHO:      cls = kbhc_pkg::CC_ECHO;
            kbhc_pkg::CMD_LEDS:      cls = kbhc_pkg::CC_LEDS;
            default:                 cls = kbhc_pkg::CC_UNKNOWN;
        endcase
        ent.is_query = (i_command == kbhc_pkg::CMD_KIND_QUERY);
        ent.cls      = ent.is_query ? kbhc_pkg::CC_QUERY : cls;
        ent.key_ok   = ({1'b0, i_data_value} < DEPTH_LIMIT);
        ent.data     = i_data_value;
    end

    assign o_ready     = (r_count != 2'd2);
    assign o_deq_valid = (r_count != 2'd0);
    assign o_deq_entry = r_ent[r_rd_ptr];
    assign push        = i_valid && o_ready;
    assign pop         = o_deq_valid && i_deq_ready;

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wr_ptr] <= ent;
        end
    end

endmodule

`default_nettype wire

@@ sv/kbhc_back.sv @@
// Back end: run one queued command against keyboard state and emit its reply bytes.
`default_nettype none

module kbhc_back #(
    parameter int KEY_MAP_DEPTH = 224
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_deq_valid,
    output logic                 o_deq_ready,
    input  kbhc_pkg::t_cmd_entry i_deq_entry,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic                 o_tx_valid,
    output logic [7:0]           o_tx_value,
    output logic                 o_last_of_run,
    output logic [1:0]           o_scan_set,
    output logic [1:0]           o_set3_mode,
    output logic                 o_enabled_flag,
    output logic [2:0]           o_led_ps2_bits,
    output logic [2:0]           o_led_usb_bits,
    output logic [18:0]          o_repeat_period_us,
    output logic [9:0]           o_repeat_delay_ms,
    output logic [1:0]           o_key_mode
);

    localparam int AW = (KEY_MAP_DEPTH > 1) ? $clog2(KEY_MAP_DEPTH) : 1;

    kbhc_pkg::t_back_state r_bk_state, n_bk_state;
    kbhc_pkg::t_wait_state r_ws, n_ws;
    logic [1:0]            r_set, n_set;
    logic [1:0]            r_glb, n_glb;
    logic                  r_en, n_en;
    logic [2:0]            r_led, n_led;
    logic [4:0]            r_rate, n_rate;
    logic [1:0]            r_delay, n_delay;
    logic [7:0]            r_last_sent, n_last_sent;

    logic [7:0]            r_tx_buf [3];
    logic [7:0]            n_tx_buf [3];
    logic [1:0]            r_tx_last, n_tx_last;
    logic [1:0]            r_tx_idx;
    logic                  r_is_query;

    logic [1:0]            r_key_mem [KEY_MAP_DEPTH];
    logic [KEY_MAP_DEPTH-1:0] r_key_vld;
    logic [1:0]            r_rd_data;
    logic                  r_rd_hit;

    logic                  deq_fire, out_fire, host_fire, query_fire;
    logic                  map_we, map_clr, cmd_path;
    logic [1:0]            map_wd;
    logic [7:0]            b;
    logic [AW-1:0]         key_idx;
    logic [7:0]            final_byte;

    assign o_deq_ready = (r_bk_state == kbhc_pkg::BK_IDLE);
    assign deq_fire    = i_deq_valid && o_deq_ready;
    assign host_fire   = deq_fire && !i_deq_entry.is_query;
    assign query_fire  = deq_fire && i_deq_entry.is_query;
    assign o_valid     = (r_bk_state == kbhc_pkg::BK_EMIT);
    assign out_fire    = o_valid && i_ready;
    assign b           = i_deq_entry.data;
    assign key_idx     = b[AW-1:0];

    // Command execution
    always_comb begin
        n_ws        = r_ws;
        n_set       = r_set;
        n_glb       = r_glb;
        n_en        = r_en;
        n_led       = r_led;
        n_rate      = r_rate;
        n_delay     = r_delay;
        n_last_sent = r_last_sent;
        n_tx_buf[0] = kbhc_pkg::RSP_ACK;
        n_tx_buf[1] = kbhc_pkg::RSP_ACK;
        n_tx_buf[2] = kbhc_pkg::RSP_ACK;
        n_tx_last   = 2'd0;
        map_we      = 1'b0;
        map_clr     = 1'b0;
        map_wd      = kbhc_pkg::KEY_ENT_NONE;
        cmd_path    = 1'b0;
        final_byte  = kbhc_pkg::RSP_ACK;

        unique case (r_ws) inside
            kbhc_pkg::WS_KEY_MAKE, kbhc_pkg::WS_KEY_MB, kbhc_pkg::WS_KEY_MT: begin
                if (i_deq_entry.key_ok) begin
                    map_we = 1'b1;
                    if (r_ws == kbhc_pkg::WS_KEY_MAKE) begin
                        map_wd = kbhc_pkg::KEY_ENT_MAKE;
                    end else if (r_ws == kbhc_pkg::WS_KEY_MB) begin
                        map_wd = kbhc_pkg::KEY_ENT_MB;
                    end else begin
                        map_wd = kbhc_pkg::KEY_ENT_MT;
                    end
                end else begin
                    cmd_path = 1'b1;
                end
            end
            kbhc_pkg::WS_LEDS: begin
                n_led = (b > 8'd7) ? 3'd0 : b[2:0];
                n_ws  = kbhc_pkg::WS_IDLE;
            end
            kbhc_pkg::WS_TYPEMATIC: begin
                n_rate  = b[4:0];
                n_delay = b[6:5];
                n_ws    = kbhc_pkg::WS_IDLE;
            end
            kbhc_pkg::WS_SCANSET: begin
                if (b == 8'd0) begin
                    n_tx_buf[0] = {6'd0, r_set};
                    n_tx_last   = 2'd1;
                end else if (b <= 8'd3) begin
                    map_clr = 1'b1;
                    n_set   = b[1:0];
                end else begin
                    n_set = kbhc_pkg::SET_TWO;
                end
                n_ws = kbhc_pkg::WS_IDLE;
            end
            default: begin
                cmd_path = 1'b1;
            end
        endcase

        if (cmd_path) begin
            n_ws = kbhc_pkg::WS_IDLE;
            unique case (i_deq_entry.cls) inside
                kbhc_pkg::CC_RESET, kbhc_pkg::CC_DEFAULTS: begin
                    n_glb   = kbhc_pkg::RST_GLOBAL;
                    n_set   = kbhc_pkg::RST_SET;
                    n_en    = 1'b1;
                    n_rate  = kbhc_pkg::RST_RATE;
                    n_delay = kbhc_pkg::RST_DELAY;
                    if (i_deq_entry.cls == kbhc_pkg::CC_RESET) begin
                        n_tx_buf[1] = kbhc_pkg::RSP_BAT_OK;
                        n_tx_last   = 2'd1;
                    end
                end
                kbhc_pkg::CC_RESEND: begin
                    n_tx_buf[0] = r_last_sent;
                end
                kbhc_pkg::CC_KEY_MAKE: begin
                    if (r_set == kbhc_pkg::SET_THREE) n_ws = kbhc_pkg::WS_KEY_MAKE;
                end
                kbhc_pkg::CC_KEY_MB: begin
                    if (r_set == kbhc_pkg::SET_THREE) n_ws = kbhc_pkg::WS_KEY_MB;
                end
                kbhc_pkg::CC_KEY_MT: begin
                    if (r_set == kbhc_pkg::SET_THREE) n_ws = kbhc_pkg::WS_KEY_MT;
                end
                kbhc_pkg::CC_GLB_ALL, kbhc_pkg::CC_GLB_MAKE,
                kbhc_pkg::CC_GLB_MB, kbhc_pkg::CC_GLB_MT: begin
                    if (r_set == kbhc_pkg::SET_THREE) begin
                        map_clr = 1'b1;
                        if (i_deq_entry.cls == kbhc_pkg::CC_GLB_ALL) begin
                            n_glb = kbhc_pkg::MODE_ALL;
                        end else if (i_deq_entry.cls == kbhc_pkg::CC_GLB_MAKE) begin
                            n_glb = kbhc_pkg::MODE_MAKE;
                        end else if (i_deq_entry.cls == kbhc_pkg::CC_GLB_MB) begin
                            n_glb = kbhc_pkg::MODE_MB;
                        end else begin
                            n_glb = kbhc_pkg::MODE_MT;
                        end
                    end
                end
                kbhc_pkg::CC_DISABLE:   n_en = 1'b0;
                kbhc_pkg::CC_ENABLE:    n_en = 1'b1;
                kbhc_pkg::CC_TYPEMATIC: n_ws = kbhc_pkg::WS_TYPEMATIC;
                kbhc_pkg::CC_READ_ID: begin
                    n_tx_buf[1] = kbhc_pkg::RSP_ID0;
                    n_tx_buf[2] = kbhc_pkg::RSP_ID1;
                    n_tx_last   = 2'd2;
                end
                kbhc_pkg::CC_SCANSET:   n_ws = kbhc_pkg::WS_SCANSET;
                kbhc_pkg::CC_ECHO:      n_tx_buf[0] = kbhc_pkg::RSP_ECHO;
                kbhc_pkg::CC_LEDS:      n_ws = kbhc_pkg::WS_LEDS;
                default:                n_tx_buf[0] = kbhc_pkg::RSP_RESEND;
            endcase
        end

        // Record the last byte sent, except a resend of the old byte or a resend request
        final_byte = n_tx_buf[n_tx_last];
        if (!(cmd_path && i_deq_entry.cls == kbhc_pkg::CC_RESEND)
            && final_byte != kbhc_pkg::RSP_RESEND) begin
            n_last_sent = final_byte;
        end
    end

    // Back-end sequencer
    always_comb begin
        n_bk_state = r_bk_state;
        unique case (r_bk_state)
            kbhc_pkg::BK_IDLE: begin
                if (deq_fire) n_bk_state = kbhc_pkg::BK_EMIT;
            end
            kbhc_pkg::BK_EMIT: begin
                if (out_fire && r_tx_idx == r_tx_last) n_bk_state = kbhc_pkg::BK_IDLE;
            end
            default: n_bk_state = kbhc_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bk_state  <= kbhc_pkg::BK_IDLE;
            r_ws        <= kbhc_pkg::WS_IDLE;
            r_set       <= kbhc_pkg::RST_SET;
            r_glb       <= kbhc_pkg::RST_GLOBAL;
            r_en        <= 1'b1;
            r_led       <= 3'd0;
            r_rate      <= kbhc_pkg::RST_RATE;
            r_delay     <= kbhc_pkg::RST_DELAY;
            r_last_sent <= 8'd0;
            r_key_vld   <= '0;
            r_tx_idx    <= 2'd0;
            r_tx_last   <= 2'd0;
            r_is_query  <= 1'b0;
        end else begin
            r_bk_state <= n_bk_state;
            if (host_fire) begin
                r_ws        <= n_ws;
                r_set       <= n_set;
                r_glb       <= n_glb;
                r_en        <= n_en;
                r_led       <= n_led;
                r_rate      <= n_rate;
                r_delay     <= n_delay;
                r_last_sent <= n_last_sent;
                r_tx_last   <= n_tx_last;
                if (map_clr) begin
                    r_key_vld <= '0;
                end else if (map_we) begin
                    r_key_vld[key_idx] <= 1'b1;
                end
            end else if (query_fire) begin
                r_tx_last <= 2'd0;
            end
            if (deq_fire) begin
                r_is_query <= i_deq_entry.is_query;
                r_tx_idx   <= 2'd0;
            end else if (out_fire) begin
                r_tx_idx <= r_tx_idx + 2'd1;
            end
        end
    end

    // Reply buffer
    always_ff @(posedge i_clk) begin
        if (host_fire) begin
            r_tx_buf[0] <= n_tx_buf[0];
            r_tx_buf[1] <= n_tx_buf[1];
            r_tx_buf[2] <= n_tx_buf[2];
        end
    end

    // Per-key mode memory; valid bits stand in for clearing it
    always_ff @(posedge i_clk) begin
        if (host_fire && map_we) begin
            r_key_mem[key_idx] <= map_wd;
        end
        if (query_fire) begin
            r_rd_data <= r_key_mem[key_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (query_fire) begin
            r_rd_hit <= i_deq_entry.key_ok ? r_key_vld[key_idx] : 1'b0;
        end
    end

    assign o_tx_valid         = !r_is_query;
    assign o_tx_value         = r_is_query ? 8'd0 : r_tx_buf[r_tx_idx];
    assign o_last_of_run      = (r_tx_idx == r_tx_last);
    assign o_scan_set         = r_set;
    assign o_set3_mode        = r_glb;
    assign o_enabled_flag     = r_en;
    assign o_led_ps2_bits     = r_led;
    assign o_led_usb_bits     = kbhc_pkg::usb_led_order(r_led);
    assign o_repeat_period_us = kbhc_pkg::rate_period_us(r_rate);
    assign o_repeat_delay_ms  = kbhc_pkg::delay_lookup(r_delay);
    assign o_key_mode         = (r_is_query && r_rd_hit) ? r_rd_data : kbhc_pkg::KEY_ENT_NONE;

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_tx_idx <= r_tx_last))
        else $error("reply index ran past the end of the run");

    a_pop_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        deq_fire |=> o_valid && r_tx_idx == 2'd0)
        else $error("popped command did not start emitting");

    a_query_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_is_query) |-> (o_last_of_run && !o_tx_valid && o_tx_value == 8'd0))
        else $error("query result is not a single empty result");

    a_status_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !(i_ready && o_last_of_run)) |=>
            ($stable(r_set) && $stable(r_glb) && $stable(r_en) && $stable(r_led)))
        else $error("status changed inside a reply run");

endmodule

`default_nettype wire

@@ sv/keyboard_host_command_handler.sv @@
// Top level of the PS/2 keyboard host command handler.
// Each input transaction is either a byte from the PS/2 host (i_command = 0) or a read of one
// entry of the set 3 per-key mode map (i_command = 1). A host byte produces one to three result
// transactions (ACK FA, resend FE, AA after reset, AB 83 for read ID, EE for echo, the set
// number for a scan set query); a map read produces exactly one result with o_tx_valid low.
// o_last_of_run marks the final result of an input, and every result carries the keyboard
// status as it stands after the whole input was handled. Inputs land in a two-entry queue
// after decoding, so the host side keeps flowing while replies are drained. The back end
// takes one queued command while idle and then emits one reply byte per cycle while the
// output side is ready; it takes no new command until the last result of a run is accepted.
// The per-key map is a memory with one valid bit per entry, so reset and the map clears of
// the global-mode and scan-set commands take effect at once with no clearing pass.
`default_nettype none

module keyboard_host_command_handler #(
    parameter int KEY_MAP_DEPTH = 224
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input channel
    input  wire         i_valid,
    output logic        o_ready,
    input  wire         i_command,
    input  wire  [7:0]  i_data_value,
    // Result channel
    output logic        o_valid,
    input  wire         i_ready,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_value,
    output logic        o_last_of_run,
    output logic [1:0]  o_scan_set,
    output logic [1:0]  o_set3_mode,
    output logic        o_enabled_flag,
    output logic [2:0]  o_led_ps2_bits,
    output logic [2:0]  o_led_usb_bits,
    output logic [18:0] o_repeat_period_us,
    output logic [9:0]  o_repeat_delay_ms,
    output logic [1:0]  o_key_mode
);

    // Decoded commands queued between front and back
    kbhc_pkg::t_cmd_entry deq_entry;
    logic                 deq_valid;
    logic                 deq_ready;

    // Front: decode and queue each incoming transaction
    kbhc_front #(
        .KEY_MAP_DEPTH (KEY_MAP_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_data_value (i_data_value),
        .o_deq_valid  (deq_valid),
        .i_deq_ready  (deq_ready),
        .o_deq_entry  (deq_entry)
    );

    // Back: execute against keyboard state, drive the reply run
    kbhc_back #(
        .KEY_MAP_DEPTH (KEY_MAP_DEPTH)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_deq_valid        (deq_valid),
        .o_deq_ready        (deq_ready),
        .i_deq_entry        (deq_entry),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_tx_valid         (o_tx_valid),
        .o_tx_value         (o_tx_value),
        .o_last_of_run      (o_last_of_run),
        .o_scan_set         (o_scan_set),
        .o_set3_mode        (o_set3_mode),
        .o_enabled_flag     (o_enabled_flag),
        .o_led_ps2_bits     (o_led_ps2_bits),
        .o_led_usb_bits     (o_led_usb_bits),
        .o_repeat_period_us (o_repeat_period_us),
        .o_repeat_delay_ms  (o_repeat_delay_ms),
        .o_key_mode         (o_key_mode)
    );

endmodule

`default_nettype wire
